[rtl/irpd_pkg.sv]
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types and constants of the pulse-distance infrared frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package irpd_pkg;

    localparam int INTERVAL_BITS_DEF = 16;
    localparam int CFG_W             = 16;
    localparam int IDX_W             = 3;
    localparam int BYTE_W            = 8;
    localparam int KIND_W            = 2;
    localparam int FAIL_W            = 4;
    localparam int NUM_BYTES         = 4;

    localparam logic [KIND_W-1:0] KIND_OK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INV    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TIMING = 2'd3;

    localparam logic [IDX_W-1:0] REG_IDLE_GAP   = 3'd0;
    localparam logic [IDX_W-1:0] REG_GLITCH_MAX = 3'd1;
    localparam logic [IDX_W-1:0] REG_SHORT_MIN  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SHORT_MAX  = 3'd3;
    localparam logic [IDX_W-1:0] REG_LONG_MIN   = 3'd4;
    localparam logic [IDX_W-1:0] REG_LONG_MAX   = 3'd5;

    localparam logic [CFG_W-1:0] IDLE_GAP_RST   = 16'd10000;
    localparam logic [CFG_W-1:0] GLITCH_MAX_RST = 16'd250;
    localparam logic [CFG_W-1:0] SHORT_MIN_RST  = 16'd400;
    localparam logic [CFG_W-1:0] SHORT_MAX_RST  = 16'd800;
    localparam logic [CFG_W-1:0] LONG_MIN_RST   = 16'd1400;
    localparam logic [CFG_W-1:0] LONG_MAX_RST   = 16'd1800;

    localparam logic [CFG_W-1:0] LEAD_MARK_MIN  = 16'd4000;
    localparam logic [CFG_W-1:0] LEAD_MARK_MAX  = 16'd9500;
    localparam logic [CFG_W-1:0] LEAD_SPACE_MIN = 16'd4000;
    localparam logic [CFG_W-1:0] LEAD_SPACE_MAX = 16'd5000;
    localparam logic [CFG_W-1:0] RPT_SPACE_MIN  = 16'd2100;
    localparam logic [CFG_W-1:0] RPT_SPACE_MAX  = 16'd2400;

    typedef struct packed {
        logic [CFG_W-1:0] idle_gap;
        logic [CFG_W-1:0] glitch_max;
        logic [CFG_W-1:0] short_min;
        logic [CFG_W-1:0] short_max;
        logic [CFG_W-1:0] long_min;
        logic [CFG_W-1:0] long_max;
    } t_cfg;

endpackage

`default_nettype wire

[rtl/irpd_core.sv]
// ----------------------------------------------------------------------------
// irpd_core
// Frame state machine, byte store and result register. Takes one edge
// interval per step and loads at most one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module irpd_core #(
    parameter int INTERVAL_BITS = irpd_pkg::INTERVAL_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic [INTERVAL_BITS-1:0]      i_interval,
    input  wire irpd_pkg::t_cfg                i_cfg,
    input  wire logic                          i_out_ready,
    output logic                               o_free,
    output logic                               o_out_valid,
    output logic [irpd_pkg::KIND_W-1:0]        o_kind,
    output logic [irpd_pkg::BYTE_W-1:0]        o_address,
    output logic [irpd_pkg::BYTE_W-1:0]        o_command,
    output logic [irpd_pkg::FAIL_W-1:0]        o_fail_state
);
    import irpd_pkg::*;

    localparam int CMP_W = (INTERVAL_BITS > CFG_W) ? INTERVAL_BITS : CFG_W;

    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_LEAD_MARK  = 4'd1,
        ST_LEAD_SPACE = 4'd2,
        ST_MARK0      = 4'd3,
        ST_SPACE0     = 4'd4,
        ST_MARK1      = 4'd5,
        ST_SPACE1     = 4'd6,
        ST_MARK2      = 4'd7,
        ST_SPACE2     = 4'd8,
        ST_MARK3      = 4'd9,
        ST_SPACE3     = 4'd10,
        ST_FINAL      = 4'd11,
        ST_RPT_MARK   = 4'd12
    } t_state;

    function automatic logic in_win(input logic [CMP_W-1:0] v,
                                    input logic [CMP_W-1:0] lo,
                                    input logic [CMP_W-1:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    t_state               r_state, n_state, s_eff;
    logic [2:0]           r_bit, n_bit, bi_eff;
    logic [BYTE_W-1:0]    r_bytes [NUM_BYTES];
    logic [BYTE_W-1:0]    n_bytes [NUM_BYTES];
    logic                 r_out_valid;
    logic [KIND_W-1:0]    r_kind, n_kind;
    logic [BYTE_W-1:0]    r_address, n_address;
    logic [BYTE_W-1:0]    r_command, n_command;
    logic [FAIL_W-1:0]    r_fail, n_fail;
    logic                 n_res;

    logic [CMP_W-1:0]     t;
    logic                 gap, glitch, win_short, win_long;
    logic [3:0]           s_off;
    logic [1:0]           byte_sel;

    assign o_free = !r_out_valid || i_out_ready;

    always_comb begin
        t         = CMP_W'(i_interval);
        gap       = t > CMP_W'(i_cfg.idle_gap);
        glitch    = t <= CMP_W'(i_cfg.glitch_max);
        win_short = in_win(t, CMP_W'(i_cfg.short_min), CMP_W'(i_cfg.short_max));
        win_long  = in_win(t, CMP_W'(i_cfg.long_min), CMP_W'(i_cfg.long_max));
        s_eff     = gap ? ST_IDLE : r_state;
        bi_eff    = gap ? 3'd7 : r_bit;
        s_off     = 4'(s_eff) - 4'(ST_SPACE0);
        byte_sel  = s_off[2:1];

        n_state   = s_eff;
        n_bit     = bi_eff;
        n_bytes   = r_bytes;
        n_res     = 1'b0;
        n_kind    = KIND_TIMING;
        n_address = '0;
        n_command = '0;
        n_fail    = 4'(s_eff);

        if (!glitch) begin
            unique case (s_eff)
                ST_LEAD_MARK: begin
                    if (in_win(t, CMP_W'(LEAD_MARK_MIN), CMP_W'(LEAD_MARK_MAX))) begin
                        n_state = ST_LEAD_SPACE;
                    end else begin
                        n_res = 1'b1;
                    end
                end
                ST_LEAD_SPACE: begin
                    if (in_win(t, CMP_W'(LEAD_SPACE_MIN), CMP_W'(LEAD_SPACE_MAX))) begin
                        n_state = ST_MARK0;
                        n_bit   = 3'd7;
                    end else if (in_win(t, CMP_W'(RPT_SPACE_MIN),
                                        CMP_W'(RPT_SPACE_MAX))) begin
                        n_state   = ST_RPT_MARK;
                        n_res     = 1'b1;
                        n_kind    = KIND_REPEAT;
                        n_address = r_bytes[0];
                        n_command = r_bytes[2];
                        n_fail    = '0;
                    end else begin
                        n_res = 1'b1;
                    end
                end
                ST_MARK0, ST_MARK1, ST_MARK2, ST_MARK3: begin
                    if (win_short) begin
                        n_state = t_state'(4'(s_eff) + 4'd1);
                    end else begin
                        n_res = 1'b1;
                    end
                end
                ST_SPACE0, ST_SPACE1, ST_SPACE2, ST_SPACE3: begin
                    if (win_long || win_short) begin
                        n_bytes[byte_sel][bi_eff] = win_long;
                        if (bi_eff == 3'd0) begin
                            n_bit   = 3'd7;
                            n_state = t_state'(4'(s_eff) + 4'd1);
                        end else begin
                            n_bit   = bi_eff - 3'd1;
                            n_state = t_state'(4'(s_eff) - 4'd1);
                        end
                    end else begin
                        n_res = 1'b1;
                    end
                end
                ST_FINAL: begin
                    if (win_short) begin
                        n_state   = ST_IDLE;
                        n_bit     = 3'd7;
                        n_res     = 1'b1;
                        n_address = r_bytes[0];
                        n_command = r_bytes[2];
                        n_fail    = '0;
                        n_kind    = ((r_bytes[0] == ~r_bytes[1]) &&
                                     (r_bytes[2] == ~r_bytes[3])) ? KIND_OK : KIND_INV;
                    end else begin
                        n_res = 1'b1;
                    end
                end
                ST_RPT_MARK: begin
                    if (win_short) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_res = 1'b1;
                    end
                end
                default: begin
                    n_state = ST_LEAD_MARK;
                    n_bit   = 3'd7;
                end
            endcase
            if (n_res && (n_kind == KIND_TIMING)) begin
                n_state = ST_IDLE;
                n_bit   = 3'd7;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bit       <= 3'd7;
            r_bytes     <= '{default: '0};
            r_out_valid <= 1'b0;
        end else begin
            if (i_step) begin
                r_state <= n_state;
                r_bit   <= n_bit;
                r_bytes <= n_bytes;
            end
            if (o_free) begin
                r_out_valid <= i_step && n_res;
            end
        end
        if (i_step && n_res) begin
            r_kind    <= n_kind;
            r_address <= n_address;
            r_command <= n_command;
            r_fail    <= n_fail;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_address    = r_address;
    assign o_command    = r_command;
    assign o_fail_state = r_fail;

endmodule

`default_nettype wire

[rtl/ir_pulse_distance_frame_decoder.sv]
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder
// Decodes pulse-distance infrared remote frames from receiver edge intervals.
//
// Input channel: one beat per receiver edge, i_interval = ticks since the
// previous edge. Output channel: one beat per reported event (frame ok,
// repeat, inverse check failed, timing error with the failing state).
// Configuration channel: i_cfg_index selects a timing register, always
// ready; write only while the decoder is idle.
// One beat a cycle is taken in sustained flow while i_ready keeps the output
// free. An accepted beat is held in the input register, and its result, if
// any, is loaded into the output register when the core steps on that beat.
// Reset (synchronous, active low) loads the default timing windows, clears
// the frame bytes and returns the decoder to idle.
// A stalled output holds its beat; the input register then holds too and
// o_ready drops until i_ready frees the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_distance_frame_decoder #(
    parameter int INTERVAL_BITS = irpd_pkg::INTERVAL_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [INTERVAL_BITS-1:0]      i_interval,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [irpd_pkg::KIND_W-1:0]        o_kind,
    output logic [irpd_pkg::BYTE_W-1:0]        o_address,
    output logic [irpd_pkg::BYTE_W-1:0]        o_command,
    output logic [irpd_pkg::FAIL_W-1:0]        o_fail_state,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [irpd_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [irpd_pkg::CFG_W-1:0]    i_cfg_data
);
    import irpd_pkg::*;

    logic                     r_in_valid;
    logic [INTERVAL_BITS-1:0] r_interval;
    t_cfg                     r_cfg;
    logic                     core_free;
    logic                     step;

    assign step        = r_in_valid && core_free;
    assign o_ready     = !r_in_valid || core_free;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_cfg.idle_gap   <= IDLE_GAP_RST;
            r_cfg.glitch_max <= GLITCH_MAX_RST;
            r_cfg.short_min  <= SHORT_MIN_RST;
            r_cfg.short_max  <= SHORT_MAX_RST;
            r_cfg.long_min   <= LONG_MIN_RST;
            r_cfg.long_max   <= LONG_MAX_RST;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_IDLE_GAP:   r_cfg.idle_gap   <= i_cfg_data;
                    REG_GLITCH_MAX: r_cfg.glitch_max <= i_cfg_data;
                    REG_SHORT_MIN:  r_cfg.short_min  <= i_cfg_data;
                    REG_SHORT_MAX:  r_cfg.short_max  <= i_cfg_data;
                    REG_LONG_MIN:   r_cfg.long_min   <= i_cfg_data;
                    REG_LONG_MAX:   r_cfg.long_max   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        if (o_ready && i_valid) begin
            r_interval <= i_interval;
        end
    end

    irpd_core #(
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_interval   (r_interval),
        .i_cfg        (r_cfg),
        .i_out_ready  (i_ready),
        .o_free       (core_free),
        .o_out_valid  (o_valid),
        .o_kind       (o_kind),
        .o_address    (o_address),
        .o_command    (o_command),
        .o_fail_state (o_fail_state)
    );

    // fail state only accompanies a timing error
    a_fail_state_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != KIND_TIMING) |-> o_fail_state == '0)
        else $error("fail state set on a non-error beat");

    a_timing_bytes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_TIMING) |-> (o_address == '0) && (o_command == '0))
        else $error("timing error beat carries frame bytes");

    // a held input beat must survive an output stall
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && o_valid && !i_ready |=> r_in_valid && $stable(r_interval))
        else $error("input beat lost during output stall");

    a_no_step_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !step)
        else $error("decoder stepped while result register full");

endmodule

`default_nettype wire

[test/tb_ir_pulse_distance_frame_decoder.sv]
// ----------------------------------------------------------------------------
// tb_ir_pulse_distance_frame_decoder
// Self-checking bench for the pulse-distance IR frame decoder. A short table
// of edge intervals covers glitches, long gaps, leader and repeat windows and
// timing errors in four of the frame states. Random frames, repeats, truncated
// frames and noise follow under several timing window settings. Every reported
// event is compared field by field with a local model of the frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ir_pulse_distance_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import irpd_pkg::*;

    localparam int IW            = INTERVAL_BITS_DEF;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 2000;

    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum logic [3:0] {
        FS_IDLE, FS_LEAD_MARK, FS_LEAD_SPACE,
        FS_A_MARK, FS_A_SPACE, FS_NA_MARK, FS_NA_SPACE,
        FS_C_MARK, FS_C_SPACE, FS_NC_MARK, FS_NC_SPACE,
        FS_FINAL, FS_RPT_MARK
    } frame_st_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] command;
        logic [FAIL_W-1:0] fail_state;
    } ir_event_t;

    typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_FIXED} row_mode_t;

    typedef struct packed {
        logic [IW-1:0] interval;
        row_mode_t     mode;
        ir_event_t     fixed;
    } edge_row_t;

    localparam ir_event_t NO_EVENT = '0;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic [IW-1:0]       i_interval  = '0;
    logic                i_ready     = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic [IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_W-1:0]    i_cfg_data  = '0;
    logic                o_ready;
    logic                o_valid;
    logic [KIND_W-1:0]   o_kind;
    logic [BYTE_W-1:0]   o_address;
    logic [BYTE_W-1:0]   o_command;
    logic [FAIL_W-1:0]   o_fail_state;
    logic                o_cfg_ready;

    ir_event_t           pending_events [$];
    logic [IW-1:0]       edge_seq [$];
    int                  mismatch_cnt = 0;
    int                  beats_sent   = 0;
    int                  burst_left   = 0;
    int                  quiet_cycles = 0;
    logic [15:0]         stall_cyc    = '0;

    // decoder image
    t_cfg                win = '{IDLE_GAP_RST, GLITCH_MAX_RST, SHORT_MIN_RST,
                                 SHORT_MAX_RST, LONG_MIN_RST, LONG_MAX_RST};
    frame_st_t           fst        = FS_IDLE;
    logic [2:0]          bit_pos    = 3'd7;
    logic [BYTE_W-1:0]   rx_bytes [NUM_BYTES] = '{default: '0};

    edge_row_t edge_tab [26] = '{
        '{16'd65535, ROW_NONE,  NO_EVENT},
        '{16'd0,     ROW_NONE,  NO_EVENT},
        '{16'd250,   ROW_NONE,  NO_EVENT},
        '{16'd251,   ROW_FIXED, '{KIND_TIMING, 8'h00, 8'h00, FS_LEAD_MARK}},
        '{16'd9500,  ROW_NONE,  NO_EVENT},
        '{16'd4000,  ROW_NONE,  NO_EVENT},
        '{16'd2100,  ROW_FIXED, '{KIND_REPEAT, 8'h00, 8'h00, FS_IDLE}},
        '{16'd800,   ROW_NONE,  NO_EVENT},
        '{16'd4000,  ROW_NONE,  NO_EVENT},
        '{16'd9500,  ROW_NONE,  NO_EVENT},
        '{16'd5000,  ROW_NONE,  NO_EVENT},
        '{16'd801,   ROW_FIXED, '{KIND_TIMING, 8'h00, 8'h00, FS_A_MARK}},
        '{16'd12345, ROW_NONE,  NO_EVENT},
        '{16'd9000,  ROW_NONE,  NO_EVENT},
        '{16'd4500,  ROW_NONE,  NO_EVENT},
        '{16'd400,   ROW_NONE,  NO_EVENT},
        '{16'd1800,  ROW_NONE,  NO_EVENT},
        '{16'd560,   ROW_NONE,  NO_EVENT},
        '{16'd1000,  ROW_FIXED, '{KIND_TIMING, 8'h00, 8'h00, FS_A_SPACE}},
        '{16'd9000,  ROW_NONE,  NO_EVENT},
        '{16'd9000,  ROW_NONE,  NO_EVENT},
        '{16'd2400,  ROW_PRED,  NO_EVENT},
        '{16'd399,   ROW_FIXED, '{KIND_TIMING, 8'h00, 8'h00, FS_RPT_MARK}},
        '{16'd10000, ROW_NONE,  NO_EVENT},
        '{16'd10001, ROW_NONE,  NO_EVENT},
        '{16'd4001,  ROW_PRED,  NO_EVENT}
    };

    ir_pulse_distance_frame_decoder u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_interval   (i_interval),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_address    (o_address),
        .o_command    (o_command),
        .o_fail_state (o_fail_state),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit in_win(input logic [IW-1:0] v, input logic [CFG_W-1:0] lo,
                                  input logic [CFG_W-1:0] hi);
        return v >= lo && v <= hi;
    endfunction

    function automatic bit timing_fail(output ir_event_t ev);
        ev = '{KIND_TIMING, 8'h00, 8'h00, fst};
        fst = FS_IDLE;
        bit_pos = 3'd7;
        return 1'b1;
    endfunction

    function automatic bit decode_edge(input logic [IW-1:0] t, output ir_event_t ev);
        frame_st_t  s;
        logic [1:0] bsel;
        ev = NO_EVENT;
        if (t > win.idle_gap) begin
            fst = FS_IDLE;
            bit_pos = 3'd7;
        end
        if (t <= win.glitch_max) return 1'b0;
        s = fst;
        case (s)
            FS_LEAD_MARK: begin
                if (!in_win(t, LEAD_MARK_MIN, LEAD_MARK_MAX)) return timing_fail(ev);
                fst = FS_LEAD_SPACE;
            end
            FS_LEAD_SPACE: begin
                if (in_win(t, LEAD_SPACE_MIN, LEAD_SPACE_MAX)) begin
                    fst = FS_A_MARK;
                    bit_pos = 3'd7;
                end else if (in_win(t, RPT_SPACE_MIN, RPT_SPACE_MAX)) begin
                    fst = FS_RPT_MARK;
                    ev = '{KIND_REPEAT, rx_bytes[0], rx_bytes[2], FS_IDLE};
                    return 1'b1;
                end else begin
                    return timing_fail(ev);
                end
            end
            FS_A_MARK, FS_NA_MARK, FS_C_MARK, FS_NC_MARK: begin
                if (!in_win(t, win.short_min, win.short_max)) return timing_fail(ev);
                fst = frame_st_t'(s + 1);
            end
            FS_A_SPACE, FS_NA_SPACE, FS_C_SPACE, FS_NC_SPACE: begin
                bsel = 2'((s - FS_A_SPACE) >> 1);
                // long window wins where the two overlap
                if (in_win(t, win.long_min, win.long_max))
                    rx_bytes[bsel][bit_pos] = 1'b1;
                else if (in_win(t, win.short_min, win.short_max))
                    rx_bytes[bsel][bit_pos] = 1'b0;
                else
                    return timing_fail(ev);
                if (bit_pos == 3'd0) begin
                    bit_pos = 3'd7;
                    fst = frame_st_t'(s + 1);
                end else begin
                    bit_pos = bit_pos - 3'd1;
                    fst = frame_st_t'(s - 1);
                end
            end
            FS_FINAL: begin
                if (!in_win(t, win.short_min, win.short_max)) return timing_fail(ev);
                fst = FS_IDLE;
                bit_pos = 3'd7;
                ev.kind = (rx_bytes[0] == ~rx_bytes[1] && rx_bytes[2] == ~rx_bytes[3]) ?
                          KIND_OK : KIND_INV;
                ev.address = rx_bytes[0];
                ev.command = rx_bytes[2];
                return 1'b1;
            end
            FS_RPT_MARK: begin
                if (!in_win(t, win.short_min, win.short_max)) return timing_fail(ev);
                fst = FS_IDLE;
            end
            default: begin
                fst = FS_LEAD_MARK;
                bit_pos = 3'd7;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic logic [IW-1:0] pick(input int unsigned lo, input int unsigned hi);
        if (lo > 65535) lo = 65535;
        if (hi > 65535) hi = 65535;
        if (hi < lo) return IW'(lo);
        return IW'($urandom_range(hi, lo));
    endfunction

    function automatic logic [IW-1:0] lead_gap();
        if (win.idle_gap != 16'hFFFF) return pick(win.idle_gap + 1, 65535);
        return pick(win.glitch_max + 1, 65535);
    endfunction

    function automatic t_cfg rand_windows();
        t_cfg c;
        c.idle_gap   = CFG_W'($urandom_range(65535, 6000));
        c.glitch_max = CFG_W'($urandom_range(399, 0));
        c.short_min  = CFG_W'($urandom_range(700, 0));
        c.short_max  = c.short_min + CFG_W'($urandom_range(900, 0));
        c.long_min   = c.short_min + CFG_W'($urandom_range(1600, 0));
        c.long_max   = c.long_min + CFG_W'($urandom_range(1000, 0));
        return c;
    endfunction

    task automatic send_beat(input logic [IW-1:0] iv, input row_mode_t mode,
                             input ir_event_t fixed);
        ir_event_t ev;
        bit        hit;
        int        gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid    <= 1'b1;
        i_interval <= iv;
        do @(posedge i_clk); while (!o_ready);
        if (iv > win.glitch_max) beats_sent++;
        hit = decode_edge(iv, ev);
        case (mode)
            ROW_PRED:  if (hit) pending_events.push_back(ev);
            ROW_FIXED: pending_events.push_back(fixed);
            default: ;
        endcase
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_IDLE_GAP:   win.idle_gap   = val;
            REG_GLITCH_MAX: win.glitch_max = val;
            REG_SHORT_MIN:  win.short_min  = val;
            REG_SHORT_MAX:  win.short_max  = val;
            REG_LONG_MIN:   win.long_min   = val;
            REG_LONG_MAX:   win.long_max   = val;
            default: ;
        endcase
    endtask

    task automatic apply_cfg(input t_cfg c);
        settle();
        write_reg(REG_IDLE_GAP,   c.idle_gap);
        write_reg(REG_GLITCH_MAX, c.glitch_max);
        write_reg(REG_SHORT_MIN,  c.short_min);
        write_reg(REG_SHORT_MAX,  c.short_max);
        write_reg(REG_LONG_MIN,   c.long_min);
        write_reg(REG_LONG_MAX,   c.long_max);
        write_reg(($urandom_range(1, 0) != 0) ? REG_SPARE_LO : REG_SPARE_HI,
                  CFG_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_frame(input bit cut);
        logic [BYTE_W-1:0] fb [NUM_BYTES];
        fb[0] = BYTE_W'($urandom);
        fb[1] = ($urandom_range(3, 0) != 0) ? ~fb[0] : BYTE_W'($urandom);
        fb[2] = BYTE_W'($urandom);
        fb[3] = ($urandom_range(3, 0) != 0) ? ~fb[2] : BYTE_W'($urandom);
        edge_seq.push_back(lead_gap());
        edge_seq.push_back(pick(LEAD_MARK_MIN, LEAD_MARK_MAX));
        edge_seq.push_back(pick(LEAD_SPACE_MIN, LEAD_SPACE_MAX));
        for (int b = 0; b < NUM_BYTES; b++) begin
            for (int k = BYTE_W - 1; k >= 0; k--) begin
                edge_seq.push_back(pick(win.short_min, win.short_max));
                edge_seq.push_back(fb[b][k] ? pick(win.long_min, win.long_max)
                                            : pick(win.short_min, win.short_max));
            end
        end
        edge_seq.push_back(pick(win.short_min, win.short_max));
        if (cut) repeat ($urandom_range(60, 1)) void'(edge_seq.pop_back());
        if ($urandom_range(4, 0) == 0)
            edge_seq[$urandom_range(edge_seq.size() - 1, 1)] = IW'($urandom);
        if ($urandom_range(5, 0) == 0)
            edge_seq.insert($urandom_range(edge_seq.size() - 1, 1), pick(0, win.glitch_max));
    endtask

    task automatic run_phase(input int budget);
        int start;
        int r;
        start = beats_sent;
        while (beats_sent - start < budget) begin
            edge_seq.delete();
            r = $urandom_range(99, 0);
            if (r < 55) begin
                add_frame(1'b0);
            end else if (r < 65) begin
                add_frame(1'b1);
            end else if (r < 82) begin
                edge_seq.push_back(lead_gap());
                edge_seq.push_back(pick(LEAD_MARK_MIN, LEAD_MARK_MAX));
                edge_seq.push_back(pick(RPT_SPACE_MIN, RPT_SPACE_MAX));
                edge_seq.push_back(pick(win.short_min, win.short_max));
            end else begin
                repeat ($urandom_range(8, 1)) begin
                    case ($urandom_range(3, 0))
                        0: edge_seq.push_back(IW'($urandom));
                        1: edge_seq.push_back(pick(0, win.glitch_max));
                        2: edge_seq.push_back(pick(win.short_min, win.long_max));
                        default: edge_seq.push_back(pick(2000, 10000));
                    endcase
                end
            end
            foreach (edge_seq[i]) send_beat(edge_seq[i], ROW_PRED, NO_EVENT);
        end
    endtask

    // receiver back-pressure, mode picked from bits 9:8 of a free-running counter
    always @(posedge i_clk) begin
        stall_cyc <= stall_cyc + 16'd1;
        case (stall_cyc[9:8])
            2'd0:    i_ready <= 1'b1;
            2'd1:    i_ready <= 1'($urandom_range(1, 0));
            2'd2:    i_ready <= (stall_cyc % 7) < 3;
            default: i_ready <= stall_cyc[4:0] < 5'd8;
        endcase
    end

    always @(posedge i_clk) begin
        ir_event_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_events.size() == 0) begin
                $display("%0t unexpected beat: kind %0d addr %h cmd %h state %0d", $time,
                         o_kind, o_address, o_command, o_fail_state);
                mismatch_cnt++;
            end else begin
                want = pending_events.pop_front();
                if (o_kind !== want.kind) begin
                    $display("%0t kind: expected %0d actual %0d", $time, want.kind, o_kind);
                    mismatch_cnt++;
                end
                if (o_address !== want.address) begin
                    $display("%0t address: expected %h actual %h", $time, want.address,
                             o_address);
                    mismatch_cnt++;
                end
                if (o_command !== want.command) begin
                    $display("%0t command: expected %h actual %h", $time, want.command,
                             o_command);
                    mismatch_cnt++;
                end
                if (o_fail_state !== want.fail_state) begin
                    $display("%0t fail_state: expected %0d actual %0d", $time,
                             want.fail_state, o_fail_state);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t timeout, %0d beats outstanding", $time, pending_events.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (edge_tab[i])
            send_beat(edge_tab[i].interval, edge_tab[i].mode, edge_tab[i].fixed);
        run_phase(200);
        apply_cfg('{16'hFFFF, 16'h0000, SHORT_MIN_RST, SHORT_MAX_RST,
                    LONG_MIN_RST, LONG_MAX_RST});
        run_phase(150);
        apply_cfg('{16'd20000, 16'd100, 16'd300, 16'd1500, 16'd1000, 16'd2000});
        run_phase(150);
        apply_cfg('{16'h0000, 16'h0000, SHORT_MIN_RST, SHORT_MAX_RST,
                    LONG_MIN_RST, LONG_MAX_RST});
        run_phase(40);
        apply_cfg(rand_windows());
        run_phase(120);
        apply_cfg(rand_windows());
        run_phase(120);
        apply_cfg('{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF});
        run_phase(60);
        apply_cfg('{IDLE_GAP_RST, GLITCH_MAX_RST, SHORT_MIN_RST, SHORT_MAX_RST,
                    LONG_MIN_RST, LONG_MAX_RST});
        run_phase(100);
        settle();
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
rtl/irpd_pkg.sv
rtl/irpd_core.sv
rtl/ir_pulse_distance_frame_decoder.sv
test/tb_ir_pulse_distance_frame_decoder.sv
